/* sv/lqph_pkg.sv */
// package: shared types, widths and codes of the quantized polynomial hash
`default_nettype none

package lqph_pkg;

    // field and register widths
    localparam int PIXEL_W   = 8;
    localparam int SHIFT_W   = 12;
    localparam int DIV_W     = 12;
    localparam int MOD_W     = 16;
    localparam int MUL_W     = 16;
    localparam int HASH_W    = 16;
    localparam int RES_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd2;

    // configuration reset values
    localparam logic [DIV_W-1:0] DIVISOR_RST    = 12'd4;
    localparam logic [MOD_W-1:0] MODULUS_RST    = 16'd255;
    localparam logic [MUL_W-1:0] MULTIPLIER_RST = 16'd16;

    // iteration counts, two bits retired per cycle
    localparam int QUOT_W    = SHIFT_W;
    localparam int FOLD_W    = 34;
    localparam int DIV_STEPS = QUOT_W / 2;
    localparam int MOD_STEPS = FOLD_W / 2;
    localparam int CNT_W     = 5;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_STEPS - 1);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_MOD,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic mod_step;
        logic commit;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } t_status;

endpackage

`default_nettype wire

/* sv/lqph_in_if.sv */
// interface: input item channel (pixel, shift, last)
`default_nettype none

interface lqph_in_if
    import lqph_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic [SHIFT_W-1:0] shift;
    logic               last;

    modport source (output valid, output pixel, output shift, output last, input ready);
    modport sink   (input valid, input pixel, input shift, input last, output ready);
endinterface

`default_nettype wire

/* sv/lqph_out_if.sv */
// interface: result item channel (hash)
`default_nettype none

interface lqph_out_if
    import lqph_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash;

    modport source (output valid, output hash, input ready);
    modport sink   (input valid, input hash, output ready);
endinterface

`default_nettype wire

/* sv/lqph_ctrl.sv */
// module: controller state machine sequencing divide, multiply and fold
`default_nettype none

module lqph_ctrl
    import lqph_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and step counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_MOD;
                n_cnt   = '0;
            end
            S_MOD: begin
                if (r_cnt == MOD_LAST) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // a final item waits for the output register to drain
                if (!i_status.last || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            S_DONE: begin
                if (!i_status.last) begin
                    o_cmd.commit = 1'b1;
                end else if (out_free) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* sv/lqph_dpath.sv */
// module: datapath with config registers, radix-4 divider, multiplier and modular fold
`default_nettype none

module lqph_dpath
    import lqph_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic [PIXEL_W-1:0]   i_pixel,
    input  wire logic [SHIFT_W-1:0]   i_shift,
    input  wire logic                 i_last,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    output logic [HASH_W-1:0]         o_hash
);

    logic [DIV_W-1:0]  r_div;
    logic [MOD_W-1:0]  r_mod;
    logic [MUL_W-1:0]  r_mul;
    logic [RES_W-1:0]  r_res, n_res;
    logic              r_neg, r_last;
    logic [QUOT_W-1:0] r_q, n_q;
    logic [MOD_W-1:0]  r_rem, n_rem;
    logic [FOLD_W-1:0] r_x, n_x;
    logic [HASH_W-1:0] r_hash;

    logic [DIV_W-1:0]       w_eff;
    logic [MOD_W-1:0]       m_eff;
    logic [SHIFT_W-1:0]     mag;
    logic [DIV_W:0]         dt1, dt2, dr1, dr2;
    logic                   dq1, dq2;
    logic [MOD_W:0]         mt1, mt2, mr1, mr2;
    logic [2*RES_W-1:0]     prod;
    logic [MOD_W+QUOT_W-1:0] addend;
    logic [FOLD_W-2:0]      fold_sum;

    // effective divisor and modulus
    assign w_eff = (r_div == '0) ? DIV_W'(1) : r_div;
    assign m_eff = (r_mod < MOD_W'(2)) ? MOD_W'(1) : r_mod;

    // magnitude of pixel minus shift
    assign mag = ({4'b0, i_pixel} >= i_shift) ? ({4'b0, i_pixel} - i_shift)
                                             : (i_shift - {4'b0, i_pixel});

    // two restoring division steps
    always_comb begin
        dt1 = {r_rem[DIV_W-1:0], r_q[QUOT_W-1]};
        dq1 = (dt1 >= {1'b0, w_eff});
        dr1 = dq1 ? (dt1 - {1'b0, w_eff}) : dt1;
        dt2 = {dr1[DIV_W-1:0], r_q[QUOT_W-2]};
        dq2 = (dt2 >= {1'b0, w_eff});
        dr2 = dq2 ? (dt2 - {1'b0, w_eff}) : dt2;
    end

    // two modular reduction steps
    always_comb begin
        mt1 = {r_rem, r_x[FOLD_W-1]};
        mr1 = (mt1 >= {1'b0, m_eff}) ? (mt1 - {1'b0, m_eff}) : mt1;
        mt2 = {mr1[MOD_W-1:0], r_x[FOLD_W-2]};
        mr2 = (mt2 >= {1'b0, m_eff}) ? (mt2 - {1'b0, m_eff}) : mt2;
    end

    // horner term: residue times multiplier plus quotient, negatives lifted by modulus
    always_comb begin
        prod     = r_res * r_mul;
        addend   = r_neg ? ({m_eff, {QUOT_W{1'b0}}} - {{MOD_W{1'b0}}, r_q})
                         : {{MOD_W{1'b0}}, r_q};
        fold_sum = {1'b0, prod} + {{(FOLD_W-1-(MOD_W+QUOT_W)){1'b0}}, addend};
    end

    // next values of the working registers
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        n_x   = r_x;
        n_res = r_res;
        if (i_cmd.load) begin
            n_q   = mag;
            n_rem = '0;
        end else if (i_cmd.div_step) begin
            n_q   = {r_q[QUOT_W-3:0], dq1, dq2};
            n_rem = {{(MOD_W-DIV_W){1'b0}}, dr2[DIV_W-1:0]};
        end else if (i_cmd.mul) begin
            n_x   = {1'b0, fold_sum};
            n_rem = '0;
        end else if (i_cmd.mod_step) begin
            n_x   = {r_x[FOLD_W-3:0], 2'b00};
            n_rem = mr2[MOD_W-1:0];
        end else if (i_cmd.commit) begin
            n_res = r_last ? '0 : RES_W'(r_rem);
        end
    end

    // config and running residue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= DIVISOR_RST;
            r_mod <= MODULUS_RST;
            r_mul <= MULTIPLIER_RST;
            r_res <= '0;
        end else begin
            r_res <= n_res;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DIVISOR:    r_div <= i_cfg_data[DIV_W-1:0];
                    CFG_MODULUS:    r_mod <= i_cfg_data[MOD_W-1:0];
                    CFG_MULTIPLIER: r_mul <= i_cfg_data[MUL_W-1:0];
                    default:        r_div <= r_div;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_x   <= n_x;
        if (i_cmd.load) begin
            r_neg  <= ({4'b0, i_pixel} < i_shift);
            r_last <= i_last;
        end
        if (i_cmd.out_load) begin
            r_hash <= HASH_W'(r_rem);
        end
    end

    assign o_status.last = r_last;
    assign o_hash        = r_hash;

endmodule

`default_nettype wire

/* sv/lsh_quantized_polynomial_hash.sv */
// top level: quantized polynomial hash with controller and datapath
// items are taken one at a time: the accepting idle state, 6 radix-4 divide steps,
// a multiply step, 17 radix-4 modular fold steps and a commit state
// a result is valid once its final item has been committed, and holds until taken
// the next item is accepted while a result waits; a later final item holds in its
// commit cycle until the output register drains; synchronous active-low reset
// restores divisor 4, modulus 255, multiplier 16, residue 0
`default_nettype none

module lsh_quantized_polynomial_hash
    import lqph_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    lqph_in_if.sink                   i_in,
    lqph_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // sequencing
    lqph_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic and state
    lqph_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pixel    (i_in.pixel),
        .i_shift    (i_in.shift),
        .i_last     (i_in.last),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_hash     (o_out.hash)
    );

endmodule

`default_nettype wire

/* sv/lqph_checker.sv */
// checker: port-level assertions for the quantized polynomial hash, with bind
`default_nettype none

module lqph_checker
    import lqph_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [HASH_W-1:0] i_hash
);

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its hash
    a_hash_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_hash))
        else $error("hash changed while stalled");

    // one item at a time: ready drops after an accepted item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accepting an item");

    // no result appears in the cycle after an item is accepted
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // a residue is always below the modulus, which is at most all ones, so the hash never reaches all ones
    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hash != {HASH_W{1'b1}})
        else $error("hash out of range");

endmodule

bind lsh_quantized_polynomial_hash lqph_checker u_lqph_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hash      (o_out.hash)
);

`default_nettype wire

/* verif/testbench.sv */
// testbench: self-checking random and directed test of the quantized polynomial hash
`default_nettype none

module testbench;
    import lqph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 110;
    localparam int RANDOM_PHASES = 10;

    // pacing of the two handshake sides
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_BOTH_IDLE,
        PACE_SRC_IDLE,
        PACE_SNK_IDLE
    } t_pace;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic [SHIFT_W-1:0] shift;
        logic               last;
    } t_pixel_elem;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;

    lqph_in_if  in_if ();
    lqph_out_if out_if ();

    lsh_quantized_polynomial_hash u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow of the configuration and the running residue
    logic [DIV_W-1:0] cfg_div = DIVISOR_RST;
    logic [MOD_W-1:0] cfg_mod = MODULUS_RST;
    logic [MUL_W-1:0] cfg_mul = MULTIPLIER_RST;
    logic [RES_W-1:0] residue_acc = '0;

    t_pixel_elem      pending_elems[$];
    t_pixel_elem      next_elem;
    logic [HASH_W-1:0] hash_expected[$];
    logic [HASH_W-1:0] fold_now;
    logic [HASH_W-1:0] hash_want;

    int    items_queued = 0;
    int    items_taken  = 0;
    int    mismatches   = 0;
    int    send_gap     = 0;
    int    take_gap     = 0;
    int    hold_left    = 0;
    bit    hold_start   = 1'b0;
    bit    in_taken     = 1'b0;
    bit    out_taken    = 1'b0;
    t_pace pace         = PACE_BOTH_IDLE;

    // clock
    always #6 i_clk = ~i_clk;

    // one element folded into the running residue by horner's rule
    function automatic logic [HASH_W-1:0] horner_fold(input logic [PIXEL_W-1:0] px,
                                                     input logic [SHIFT_W-1:0] sh);
        longint unsigned w;
        longint unsigned m;
        longint unsigned q;
        longint unsigned a;
        longint unsigned h;
        w = (cfg_div == '0) ? 1 : longint'(cfg_div);
        m = (cfg_mod < 2) ? 1 : longint'(cfg_mod);
        // truncation toward zero, negative quotients mapped to their residue
        if (px >= sh) begin
            a = ((longint'(px) - longint'(sh)) / w) % m;
        end else begin
            q = (longint'(sh) - longint'(px)) / w;
            a = (m - (q % m)) % m;
        end
        h = ((longint'(residue_acc) % m) * (longint'(cfg_mul) % m) + a) % m;
        return HASH_W'(h);
    endfunction

    function automatic void push_elem(input logic [PIXEL_W-1:0] px,
                                      input logic [SHIFT_W-1:0] sh, input logic lst);
        t_pixel_elem e;
        e.pixel = px;
        e.shift = sh;
        e.last  = lst;
        pending_elems.insert(pending_elems.size(), e);
        items_queued++;
    endfunction

    function automatic int draw_wait(input bit idle_side);
        return idle_side ? $urandom_range(0, 19) : 0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [HASH_W-1:0] want,
                                 input logic [HASH_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d: %s expected %0d got %0d", mismatches, what, want, got);
    endtask

    // wait until every item is taken and every hash seen, then let the block go idle
    task automatic settle();
        while (items_taken != items_queued || hash_expected.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // all three registers written on consecutive cycles while idle
    task automatic start_phase(input logic [DIV_W-1:0] dv, input logic [MOD_W-1:0] md,
                               input logic [MUL_W-1:0] ml, input t_pace pc);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DIVISOR;
        cfg_data <= CFG_DAT_W'(dv);
        @(negedge i_clk);
        cfg_idx  <= CFG_MODULUS;
        cfg_data <= CFG_DAT_W'(md);
        @(negedge i_clk);
        cfg_idx  <= CFG_MULTIPLIER;
        cfg_data <= CFG_DAT_W'(ml);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cfg_div  = dv;
        cfg_mod  = md;
        cfg_mul  = ml;
        @(posedge i_clk);
        pace = pc;
    endtask

    // random vectors, mostly short, sometimes left open at the end of the phase
    task automatic queue_random_phase(input int count, input bit open_end);
        int n;
        int len;
        int k;
        logic [PIXEL_W-1:0] px;
        logic [SHIFT_W-1:0] sh;
        n = 0;
        while (n < count) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 5);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = PIXEL_W'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       sh = SHIFT_W'($urandom);
                    1:       sh = SHIFT_W'(px) + SHIFT_W'($urandom_range(0, 3));
                    default: sh = SHIFT_W'($urandom_range(0, cfg_div));
                endcase
                push_elem(px, sh, k == len - 1);
                n++;
                if (open_end && n >= count)
                    return;
            end
        end
    endtask

    // input driver: one item per handshake, with a random gap after each when the pace idles the source
    always @(negedge i_clk) begin
        if (in_taken)
            send_gap = draw_wait(pace == PACE_BOTH_IDLE || pace == PACE_SRC_IDLE);
        if (!in_if.valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_elems.size() > 0) begin
                next_elem    = pending_elems.pop_front();
                in_if.valid <= 1'b1;
                in_if.pixel <= next_elem.pixel;
                in_if.shift <= next_elem.shift;
                in_if.last  <= next_elem.last;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // result receiver: random stall after each item when the pace idles the sink, ready low during the hold-off
    always @(negedge i_clk) begin
        if (out_taken)
            take_gap = draw_wait(pace == PACE_BOTH_IDLE || pace == PACE_SNK_IDLE);
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // monitor: check results, then predict from the accepted input item
    always @(posedge i_clk) begin
        in_taken  = i_rst_n && in_if.valid && in_if.ready;
        out_taken = i_rst_n && out_if.valid && out_if.ready;
        if (out_taken) begin
            if (hash_expected.size() == 0) begin
                flag_mismatch("hash with nothing expected", 'x, out_if.hash);
            end else begin
                hash_want = hash_expected.pop_front();
                if (out_if.hash !== hash_want)
                    flag_mismatch("hash", hash_want, out_if.hash);
            end
        end
        if (in_taken) begin
            fold_now = horner_fold(in_if.pixel, in_if.shift);
            if (in_if.last) begin
                hash_expected.insert(hash_expected.size(), fold_now);
                residue_acc = '0;
            end else begin
                residue_acc = fold_now;
            end
            items_taken++;
        end
    end

    // stimulus sequence
    initial begin
        int ph;
        logic [DIV_W-1:0] dv;
        logic [MOD_W-1:0] md;
        logic [MUL_W-1:0] ml;

        in_if.valid  = 1'b0;
        in_if.pixel  = '0;
        in_if.shift  = '0;
        in_if.last   = 1'b0;
        out_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_DIVISOR;
        cfg_data     = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: field extremes, negative quotient, exact shift
        push_elem(8'd255, 12'd0, 1'b1);
        push_elem(8'd0, 12'd4095, 1'b1);
        push_elem(8'd0, 12'd0, 1'b1);
        push_elem(8'd200, 12'd3, 1'b0);
        push_elem(8'd17, 12'd100, 1'b0);
        push_elem(8'd255, 12'd4095, 1'b1);
        push_elem(8'd3, 12'd3, 1'b1);
        // vector left open so the residue carries into the next setting
        push_elem(8'd128, 12'd2048, 1'b0);
        push_elem(8'd1, 12'd0, 1'b0);
        settle();

        // zero divisor, smallest modulus below the stored residue, multiplier all ones
        start_phase(12'd0, 16'd2, 16'hFFFF, PACE_BOTH_IDLE);
        push_elem(8'd255, 12'd0, 1'b1);
        push_elem(8'd0, 12'd255, 1'b1);
        settle();

        // widest divisor, modulus zero, multiplier zero
        start_phase(12'd4095, 16'd0, 16'd0, PACE_FULL);
        push_elem(8'd255, 12'd4095, 1'b0);
        push_elem(8'd100, 12'd0, 1'b1);
        settle();

        // modulus one
        start_phase(12'd1, 16'd1, 16'd65534, PACE_BOTH_IDLE);
        push_elem(8'd7, 12'd9, 1'b1);
        settle();

        // widest modulus, largest in-range multiplier
        start_phase(12'd1, 16'd65535, 16'd65534, PACE_BOTH_IDLE);
        push_elem(8'd255, 12'd0, 1'b0);
        push_elem(8'd0, 12'd4095, 1'b0);
        push_elem(8'd255, 12'd1, 1'b1);
        settle();

        // multiplier equal to and above the modulus
        start_phase(12'd2, 16'd65535, 16'd65535, PACE_FULL);
        push_elem(8'd9, 12'd0, 1'b0);
        push_elem(8'd0, 12'd9, 1'b1);
        settle();
        start_phase(12'd3, 16'd7, 16'd200, PACE_BOTH_IDLE);
        push_elem(8'd255, 12'd0, 1'b0);
        push_elem(8'd0, 12'd4095, 1'b1);
        settle();

        // random phases, each under a fresh configuration
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       dv = '0;
                1:       dv = 12'd1;
                2:       dv = 12'd4095;
                3:       dv = DIV_W'($urandom_range(1, 8));
                default: dv = DIV_W'($urandom_range(1, 4095));
            endcase
            case ($urandom_range(0, 6))
                0:       md = '0;
                1:       md = 16'd1;
                2:       md = 16'd2;
                3:       md = 16'd65535;
                4:       md = MOD_W'($urandom_range(2, 300));
                default: md = MOD_W'($urandom_range(2, 65535));
            endcase
            case ($urandom_range(0, 5))
                0:       ml = '0;
                1:       ml = 16'd65534;
                2:       ml = 16'd65535;
                3:       ml = (md == '0) ? '0 : MUL_W'($urandom_range(0, md - 1));
                default: ml = MUL_W'($urandom);
            endcase
            start_phase(dv, md, ml, t_pace'(ph % 4));
            queue_random_phase(PHASE_ITEMS, ph % 3 == 1);
            // receiver backs off while the sender keeps offering items
            if (ph == 4) begin
                @(negedge i_clk);
                hold_start = 1'b1;
            end
            settle();
        end

        if (mismatches == 0 && hash_expected.size() == 0) begin
            $display("lsh_quantized_polynomial_hash verification clean");
        end else begin
            $display("lsh_quantized_polynomial_hash verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("lsh_quantized_polynomial_hash verification failed");
        $finish;
    end

endmodule

`default_nettype wire
